// ===== sv/bsm_pkg.sv =====
// Shared types and constants of the stack machine execution unit.
// Used by bsm_cell, the top module, the checker and the testbench; depends on nothing.
package bsm_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_REGS_DEF    = 8;

    typedef enum logic [3:0] {
        ACT_PUSH    = 4'd0,
        ACT_POP     = 4'd1,
        ACT_TOREG   = 4'd2,
        ACT_FROMREG = 4'd3,
        ACT_CMP     = 4'd4,
        ACT_ADD     = 4'd5,
        ACT_SUB     = 4'd6,
        ACT_MUL     = 4'd7,
        ACT_DIV     = 4'd8,
        ACT_JMP     = 4'd9,
        ACT_JIE     = 4'd10,
        ACT_JINE    = 4'd11,
        ACT_JIG     = 4'd12,
        ACT_JIL     = 4'd13,
        ACT_JIEG    = 4'd14,
        ACT_JIEL    = 4'd15
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_BADREG  = 3'd3,
        ST_DIVZERO = 3'd4
    } t_status;

    // What one stack cell loads in a cycle.
    typedef enum logic [1:0] {
        SH_HOLD  = 2'd0,
        SH_ABOVE = 2'd1,
        SH_DN1   = 2'd2,
        SH_DN2   = 2'd3
    } t_shift;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] operand;
    } t_item;

    typedef struct packed {
        logic       branch_taken;
        logic [7:0] top_value;
        logic [2:0] status;
    } t_result;

endpackage

// ===== sv/bsm_cell.sv =====
// One entry of the value stack, kept as a cell of a shifting chain.
// Depends on bsm_pkg for the shift command type.
module bsm_cell (
    input  logic           i_clk,
    input  bsm_pkg::t_shift i_op,
    input  logic [7:0]     i_above,
    input  logic [7:0]     i_dn1,
    input  logic [7:0]     i_dn2,
    output logic [7:0]     o_val
);
    import bsm_pkg::*;

    logic [7:0] r_val;
    logic [7:0] n_val;

    always_comb begin
        unique case (i_op)
            SH_HOLD:  n_val = r_val;
            SH_ABOVE: n_val = i_above;
            SH_DN1:   n_val = i_dn1;
            SH_DN2:   n_val = i_dn2;
            default:  n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// ===== sv/bsm_div.sv =====
// Unsigned 8-bit restoring divider, two quotient bits per cycle.
// Depends on nothing; the divisor is nonzero whenever it is started.
module bsm_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_dividend,
    input  logic [7:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quotient
);
    logic       r_busy;
    logic       r_done;
    logic [1:0] r_cnt;
    logic [8:0] r_rem;
    logic [7:0] r_quo;
    logic [7:0] r_dvs;
    logic [8:0] n_rem;
    logic [7:0] n_quo;

    // Two dependent shift-subtract steps on 9-bit values.
    always_comb begin
        logic [8:0] rem;
        logic [7:0] quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            rem = {rem[7:0], quo[7]};
            quo = {quo[6:0], 1'b0};
            if (rem >= {1'b0, r_dvs}) begin
                rem    = rem - {1'b0, r_dvs};
                quo[0] = 1'b1;
            end
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/bsm_regfile.sv =====
// General register file: one write port, one registered read port.
// Valid bits make unwritten registers read as zero; no package needed.
module bsm_regfile #(
    parameter  int NUM_REGS = 8,
    localparam int RegIdxW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [RegIdxW-1:0] i_rd_idx,
    input  logic               i_wr_en,
    input  logic [RegIdxW-1:0] i_wr_idx,
    input  logic [7:0]         i_wr_data,
    output logic [7:0]         o_rd_data
);
    logic [7:0]          r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [7:0]          r_rd_mem;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_mem <= r_mem[i_rd_idx];
            r_rd_vld <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_mem : 8'd0;

endmodule

// ===== sv/byte_stack_machine_execute.sv =====
// Stack machine execution unit: one decoded instruction per transfer in, one result out.
// An instruction is accepted and then executed; a div is accepted, started in the execute step,
// run through the four passes of the two-bit-per-cycle divider, waits for its done flag and commits.
// A full, stalled output register holds the commit, and input stays stalled until the unit is idle.
// Depends on bsm_pkg, bsm_cell, bsm_div and bsm_regfile.
module byte_stack_machine_execute #(
    parameter int STACK_DEPTH = bsm_pkg::STACK_DEPTH_DEF,
    parameter int NUM_REGS    = bsm_pkg::NUM_REGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bsm_pkg::t_item   i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output bsm_pkg::t_result o_out
);
    import bsm_pkg::*;

    localparam int DepthW  = $clog2(STACK_DEPTH + 1);
    localparam int RegIdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_COMMIT
    } t_state;

    typedef enum logic [2:0] {
        K_HOLD,
        K_PUSH,
        K_POP1,
        K_POP2,
        K_REPL
    } t_kind;

    t_state            r_state;
    t_action           r_act;
    logic [7:0]        r_opd;
    logic [DepthW-1:0] r_depth;
    logic              r_flag_eq;
    logic              r_flag_gt;
    logic              r_flag_lt;
    t_result           r_out;
    logic              r_out_valid;

    logic [7:0]        w_cell [STACK_DEPTH + 2];
    logic [7:0]        w_reg_rd;
    logic              w_div_done;
    logic [7:0]        w_quo;
    logic [15:0]       w_prod;
    logic              w_accept;
    logic              w_out_free;
    logic              w_commit;
    logic              w_div_go;
    t_kind             w_kind;
    t_status           w_status;
    logic              w_taken;
    logic [7:0]        w_new_val;
    logic              w_set_flags;
    logic              w_reg_we;
    logic              w_bad_reg;
    logic              w_full;
    logic              w_empty;
    logic [DepthW-1:0] n_depth;
    logic [7:0]        n_top;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_bad_reg = {1'b0, r_opd} >= 9'(NUM_REGS);
    assign w_full    = (r_depth == DepthW'(STACK_DEPTH));
    assign w_empty   = (r_depth == '0);
    assign w_prod    = w_cell[1] * w_cell[0];

    // Top of stack is cell 0, the second operand; cell 1 is the first operand.
    always_comb begin
        w_kind      = K_HOLD;
        w_status    = ST_OK;
        w_taken     = 1'b0;
        w_new_val   = r_opd;
        w_set_flags = 1'b0;
        w_reg_we    = 1'b0;
        unique case (r_act)
            ACT_PUSH: begin
                if (w_full) w_status = ST_OVER;
                else        w_kind   = K_PUSH;
            end
            ACT_POP: begin
                if (w_empty) w_status = ST_UNDER;
                else         w_kind   = K_POP1;
            end
            ACT_TOREG: begin
                if (w_bad_reg) begin
                    w_status = ST_BADREG;
                end else if (w_empty) begin
                    w_status = ST_UNDER;
                end else begin
                    w_kind   = K_POP1;
                    w_reg_we = 1'b1;
                end
            end
            ACT_FROMREG: begin
                if (w_bad_reg) begin
                    w_status = ST_BADREG;
                end else if (w_full) begin
                    w_status = ST_OVER;
                end else begin
                    w_kind    = K_PUSH;
                    w_new_val = w_reg_rd;
                end
            end
            ACT_CMP, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                // A zero divisor is reported as soon as one entry is present.
                if (w_empty) begin
                    w_status = ST_UNDER;
                end else if (r_act == ACT_DIV && w_cell[0] == 8'd0) begin
                    w_status = ST_DIVZERO;
                end else if (r_depth < DepthW'(2)) begin
                    w_status = ST_UNDER;
                end else if (r_act == ACT_CMP) begin
                    w_kind      = K_POP2;
                    w_set_flags = 1'b1;
                end else begin
                    w_kind = K_REPL;
                    priority case (r_act)
                        ACT_ADD: w_new_val = w_cell[1] + w_cell[0];
                        ACT_SUB: w_new_val = w_cell[1] - w_cell[0];
                        ACT_MUL: w_new_val = w_prod[7:0];
                        default: w_new_val = w_quo;
                    endcase
                end
            end
            ACT_JMP:  w_taken = 1'b1;
            ACT_JIE:  w_taken = r_flag_eq;
            ACT_JINE: w_taken = !r_flag_eq;
            ACT_JIG:  w_taken = r_flag_gt;
            ACT_JIL:  w_taken = r_flag_lt;
            ACT_JIEG: w_taken = r_flag_eq || r_flag_gt;
            ACT_JIEL: w_taken = r_flag_eq || r_flag_lt;
            default:  w_taken = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_kind)
            K_HOLD: begin n_depth = r_depth;               n_top = w_cell[0]; end
            K_PUSH: begin n_depth = r_depth + DepthW'(1);  n_top = w_new_val; end
            K_POP1: begin n_depth = r_depth - DepthW'(1);  n_top = w_cell[1]; end
            K_POP2: begin n_depth = r_depth - DepthW'(2);  n_top = w_cell[2]; end
            K_REPL: begin n_depth = r_depth - DepthW'(1);  n_top = w_new_val; end
            default: begin n_depth = r_depth;              n_top = w_cell[0]; end
        endcase
    end

    assign w_div_go = (r_state == S_EXEC) && (r_act == ACT_DIV) && (w_status == ST_OK);
    assign w_commit = (((r_state == S_EXEC) && !w_div_go) || (r_state == S_COMMIT))
                      && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_flag_eq   <= 1'b0;
            r_flag_gt   <= 1'b0;
            r_flag_lt   <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_div_go)      r_state <= S_DIV;
                    else if (w_commit) r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (w_div_done) r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_commit) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_commit) begin
                r_depth <= n_depth;
                if (w_set_flags) begin
                    r_flag_eq <= (w_cell[1] == w_cell[0]);
                    r_flag_gt <= (w_cell[1] > w_cell[0]);
                    r_flag_lt <= (w_cell[1] < w_cell[0]);
                end
            end
        end
        if (w_accept) begin
            r_act <= t_action'(i_in.action);
            r_opd <= i_in.operand;
        end
        if (w_commit) begin
            r_out.branch_taken <= w_taken;
            r_out.top_value    <= (n_depth == '0) ? 8'd0 : n_top;
            r_out.status       <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Stack chain: cell i takes from cell i-1 (cell 0 the new value) on a push, from i+1 or i+2 on pops.
    assign w_cell[STACK_DEPTH]     = 8'd0;
    assign w_cell[STACK_DEPTH + 1] = 8'd0;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        t_shift     w_op;
        logic [7:0] w_above;

        assign w_above = (i == 0) ? w_new_val : w_cell[(i == 0) ? 0 : i - 1];

        always_comb begin
            w_op = SH_HOLD;
            if (w_commit) begin
                unique case (w_kind)
                    K_HOLD:  w_op = SH_HOLD;
                    K_PUSH:  w_op = SH_ABOVE;
                    K_POP1:  w_op = SH_DN1;
                    K_POP2:  w_op = SH_DN2;
                    K_REPL:  w_op = (i == 0) ? SH_ABOVE : SH_DN1;
                    default: w_op = SH_HOLD;
                endcase
            end
        end

        bsm_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_above (w_above),
            .i_dn1   (w_cell[i + 1]),
            .i_dn2   (w_cell[i + 2]),
            .o_val   (w_cell[i])
        );
    end

    bsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (w_cell[1]),
        .i_divisor  (w_cell[0]),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    bsm_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_idx  (i_in.operand[RegIdxW-1:0]),
        .i_wr_en   (w_commit && w_reg_we),
        .i_wr_idx  (r_opd[RegIdxW-1:0]),
        .i_wr_data (w_cell[0]),
        .o_rd_data (w_reg_rd)
    );

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DepthW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_fault_no_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_OK) |-> !o_out.branch_taken)
        else $error("faulting instruction reports a taken branch");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_depth == '0) |-> (o_out.top_value == 8'd0))
        else $error("empty stack reports a nonzero top value");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside a divide");

endmodule

// ===== test/bsm_exec_checker.sv =====
// Checker for the stack machine execution unit: watches both channels, predicts each result
// from accepted instructions with its own copy of stack, registers and flags, and compares.
// Depends on bsm_pkg for the payload types, action and status codes.
module bsm_exec_checker
    import bsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  t_item   i_in,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_result i_out,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_depth
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_CELLS = STACK_DEPTH_DEF;
    localparam int REG_COUNT   = NUM_REGS_DEF;

    logic [7:0] stack_mem [STACK_CELLS];
    logic [7:0] gp_regs [REG_COUNT];
    int         depth;
    logic       eq_flag;
    logic       gt_flag;
    logic       lt_flag;
    t_result    expected_results [$];
    int         results_seen;

    // Applies one instruction to the shadow state and returns the result it must produce.
    function automatic t_result execute_instr(t_item it);
        t_action    act;
        t_status    st;
        logic       taken;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        t_result    res;
        act   = t_action'(it.action);
        st    = ST_OK;
        taken = 1'b0;
        r     = 8'd0;
        case (act)
            ACT_PUSH: begin
                if (depth >= STACK_CELLS) begin
                    st = ST_OVER;
                end else begin
                    stack_mem[depth] = it.operand;
                    depth++;
                end
            end
            ACT_POP: begin
                if (depth == 0) st = ST_UNDER;
                else depth--;
            end
            ACT_TOREG: begin
                if (it.operand >= REG_COUNT) begin
                    st = ST_BADREG;
                end else if (depth == 0) begin
                    st = ST_UNDER;
                end else begin
                    depth--;
                    gp_regs[it.operand] = stack_mem[depth];
                end
            end
            ACT_FROMREG: begin
                if (it.operand >= REG_COUNT) begin
                    st = ST_BADREG;
                end else if (depth >= STACK_CELLS) begin
                    st = ST_OVER;
                end else begin
                    stack_mem[depth] = gp_regs[it.operand];
                    depth++;
                end
            end
            ACT_CMP, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                // The divisor is checked as soon as one entry exists, so a lone zero
                // reports divide by zero rather than underflow.
                b = (depth >= 1) ? stack_mem[depth - 1] : 8'd0;
                if (depth < 1) begin
                    st = ST_UNDER;
                end else if (act == ACT_DIV && b == 8'd0) begin
                    st = ST_DIVZERO;
                end else if (depth < 2) begin
                    st = ST_UNDER;
                end else begin
                    a = stack_mem[depth - 2];
                    depth -= 2;
                    case (act)
                        ACT_CMP: begin
                            eq_flag = (a == b);
                            gt_flag = (a > b);
                            lt_flag = (a < b);
                        end
                        ACT_ADD: r = a + b;
                        ACT_SUB: r = a - b;
                        ACT_MUL: r = a * b;
                        default: r = a / b;
                    endcase
                    if (act != ACT_CMP) begin
                        stack_mem[depth] = r;
                        depth++;
                    end
                end
            end
            ACT_JMP:  taken = 1'b1;
            ACT_JIE:  taken = eq_flag;
            ACT_JINE: taken = !eq_flag;
            ACT_JIG:  taken = gt_flag;
            ACT_JIL:  taken = lt_flag;
            ACT_JIEG: taken = eq_flag || gt_flag;
            default:  taken = eq_flag || lt_flag;
        endcase
        res.branch_taken = taken;
        res.top_value    = (depth == 0) ? 8'd0 : stack_mem[depth - 1];
        res.status       = st;
        return res;
    endfunction

    function automatic void note_failure(string what);
        o_fail_count++;
        if (o_fail_count <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (stack_mem[k]) stack_mem[k] = 8'd0;
            foreach (gp_regs[k]) gp_regs[k] = 8'd0;
            depth        = 0;
            eq_flag      = 1'b0;
            gt_flag      = 1'b0;
            lt_flag      = 1'b0;
            results_seen = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with none outstanding",
                                           results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.branch_taken !== want.branch_taken ||
                        i_out.top_value !== want.top_value ||
                        i_out.status !== want.status) begin
                        note_failure($sformatf(
                            "result %0d: expected taken=%0d top=%0d status=%0d, got taken=%0d top=%0d status=%0d",
                            results_seen, want.branch_taken, want.top_value, want.status,
                            i_out.branch_taken, i_out.top_value, i_out.status));
                    end
                end
                results_seen++;
            end
            if (i_in_valid && !i_in_stall) expected_results.push_back(execute_instr(i_in));
        end
        o_pending = expected_results.size();
        o_depth   = depth;
    end

endmodule

// ===== test/tb_byte_stack_machine_execute.sv =====
// Top of the execution unit testbench: clock, reset, instruction stimulus and the verdict.
// Depends on bsm_pkg, the byte_stack_machine_execute block and bsm_exec_checker.
module tb_byte_stack_machine_execute;
    timeunit 1ns;
    timeprecision 1ps;

    import bsm_pkg::*;

    localparam int PHASE_ITEMS = 560;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    t_item   in_item = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    t_result out_res;
    int      fail_count;
    int      pending;
    int      exec_depth;

    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      depth_guess = 0;
    bit      climbing = 1'b1;

    byte_stack_machine_execute dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    bsm_exec_checker exec_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_depth      (exec_depth)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic t_item instr(t_action act, logic [7:0] opd);
        t_item it;
        it.action  = act;
        it.operand = opd;
        return it;
    endfunction

    task automatic send_instr(input t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // Rough depth estimate used only to steer stimulus; divide by zero is not
        // modeled here, the estimate is corrected at every drain.
        case (t_action'(it.action))
            ACT_PUSH: if (depth_guess < STACK_DEPTH_DEF) depth_guess++;
            ACT_POP: if (depth_guess > 0) depth_guess--;
            ACT_TOREG: if (it.operand < NUM_REGS_DEF && depth_guess > 0) depth_guess--;
            ACT_FROMREG: begin
                if (it.operand < NUM_REGS_DEF && depth_guess < STACK_DEPTH_DEF) depth_guess++;
            end
            ACT_CMP: if (depth_guess >= 2) depth_guess -= 2;
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: if (depth_guess >= 2) depth_guess--;
            default: ;
        endcase
    endtask

    // Holds the sender off until every outstanding result has been received.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        depth_guess = exec_depth;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count);
        t_action    act;
        logic [7:0] opd;
        int         up_pct;
        for (int n = 0; n < count; n++) begin
            // Alternate between filling and emptying so both stack limits get hit.
            if ($urandom_range(0, 39) == 0) climbing = !climbing;
            up_pct = (depth_guess < 2) ? 80 : (climbing ? 65 : 25);
            if ($urandom_range(0, 99) < up_pct) begin
                act = ($urandom_range(0, 3) == 0) ? ACT_FROMREG : ACT_PUSH;
            end else if ($urandom_range(0, 9) < 6) begin
                act = t_action'($urandom_range(int'(ACT_POP), int'(ACT_DIV)));
                if (act == ACT_FROMREG) act = ACT_DIV;
            end else begin
                act = t_action'($urandom_range(int'(ACT_CMP), int'(ACT_JIEL)));
            end
            case (act)
                ACT_PUSH: opd = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
                ACT_TOREG, ACT_FROMREG: begin
                    opd = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NUM_REGS_DEF, 255))
                                                      : 8'($urandom_range(0, NUM_REGS_DEF - 1));
                end
                default: opd = 8'($urandom_range(0, 255));
            endcase
            send_instr(instr(act, opd));
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 22;
        recv_stall_pct <= 76;

        // Faults on an empty stack; a bad register is reported before underflow.
        send_instr(instr(ACT_POP, 8'd0));
        send_instr(instr(ACT_TOREG, 8'hFF));
        send_instr(instr(ACT_TOREG, 8'd0));
        send_instr(instr(ACT_CMP, 8'd0));
        // A single zero entry gives divide by zero, not underflow.
        send_instr(instr(ACT_PUSH, 8'd0));
        send_instr(instr(ACT_DIV, 8'd0));
        send_instr(instr(ACT_MUL, 8'd0));
        // Wrapping add, sub and mul, then an ordinary divide.
        send_instr(instr(ACT_PUSH, 8'hFF));
        send_instr(instr(ACT_PUSH, 8'd1));
        send_instr(instr(ACT_ADD, 8'd0));
        send_instr(instr(ACT_PUSH, 8'd3));
        send_instr(instr(ACT_SUB, 8'd0));
        send_instr(instr(ACT_PUSH, 8'd200));
        send_instr(instr(ACT_MUL, 8'd0));
        send_instr(instr(ACT_PUSH, 8'd7));
        send_instr(instr(ACT_DIV, 8'd0));
        send_instr(instr(ACT_TOREG, 8'd7));
        send_instr(instr(ACT_FROMREG, 8'd8));
        send_instr(instr(ACT_FROMREG, 8'd7));
        send_instr(instr(ACT_CMP, 8'd0));
        for (int j = ACT_JMP; j <= ACT_JIEL; j++) send_instr(instr(t_action'(j), 8'hA5));

        run_phase(PHASE_ITEMS);
        drain();
        send_idle_pct = 76;
        recv_stall_pct <= 22;
        run_phase(PHASE_ITEMS);
        drain();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        run_phase(PHASE_ITEMS);
        drain();
        repeat (16) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("byte_stack_machine_execute verification clean");
        end else begin
            $display("byte_stack_machine_execute verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("byte_stack_machine_execute verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bsm_pkg.sv
sv/bsm_cell.sv
sv/bsm_div.sv
sv/bsm_regfile.sv
sv/byte_stack_machine_execute.sv
test/bsm_exec_checker.sv
test/tb_byte_stack_machine_execute.sv
